FILE: hw/rtl/b2d_pkg.sv
package b2d_pkg;

  localparam int VALUE_BITS = 32;
  localparam int WORD_BITS  = 32;
  localparam int DIGITS     = (WORD_BITS * 301) / 1000 + 1;
  localparam int BCD_BITS   = 4 * DIGITS;
  localparam int STEPS      = 4;
  localparam int STAGES     = (WORD_BITS + STEPS - 1) / STEPS;
  localparam int IDX_BITS   = $clog2(DIGITS);

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef struct packed {
    logic [BCD_BITS-1:0]  bcd;
    logic [WORD_BITS-1:0] bin;
    logic                 neg;
  } b2d_work_t;

  typedef struct packed {
    logic [BCD_BITS-1:0] bcd;
    logic                neg;
  } b2d_num_t;

  // one shift-and-add-3 step
  function automatic b2d_work_t dabble_step(input b2d_work_t w);
    b2d_work_t  r;
    logic [3:0] d;
    r = w;
    for (int i = 0; i < DIGITS; i++) begin
      d = r.bcd[4*i +: 4];
      if (d >= 4'd5) begin
        r.bcd[4*i +: 4] = d + 4'd3;
      end
    end
    {r.bcd, r.bin} = {r.bcd[BCD_BITS-2:0], r.bin, 1'b0};
    return r;
  endfunction

endpackage

FILE: hw/rtl/b2d_if.sv
interface b2d_in_if import b2d_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  mode;

  modport source (output valid, output value, output mode, input ready);
  modport sink (input valid, input value, input mode, output ready);
endinterface

interface b2d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

FILE: hw/rtl/b2d_dabble.sv
module b2d_dabble import b2d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  mode,
  output logic                  out_valid,
  input  logic                  out_ready,
  output b2d_num_t              out_num
);

  b2d_work_t            st [STAGES+1];
  b2d_work_t            st_next [STAGES+1];
  logic [STAGES:0]      vld;
  logic [STAGES:0]      rdy;
  logic [WORD_BITS-1:0] word;
  logic                 neg;

  // stage 0: magnitude
  always_comb begin
    word = WORD_BITS'(value);
    neg  = word[WORD_BITS-1] & ~mode;
    st_next[0].bcd = '0;
    st_next[0].bin = neg ? (~word + 1'b1) : word;
    st_next[0].neg = neg;
  end

  for (genvar s = 1; s <= STAGES; s++) begin : g_stage
    always_comb begin
      st_next[s] = st[s-1];
      for (int j = 0; j < STEPS; j++) begin
        if ((s - 1) * STEPS + j < WORD_BITS) begin
          st_next[s] = dabble_step(st_next[s]);
        end
      end
    end
  end

  for (genvar s = 0; s <= STAGES; s++) begin : g_reg
    if (s == STAGES) begin : g_tail
      assign rdy[s] = ~vld[s] | out_ready;
    end else begin : g_body
      assign rdy[s] = ~vld[s] | rdy[s+1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= (s == 0) ? in_valid : vld[(s == 0) ? 0 : s - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        st[s] <= st_next[s];
      end
    end
  end

  assign in_ready    = rdy[0];
  assign out_valid   = vld[STAGES];
  assign out_num.bcd = st[STAGES].bcd;
  assign out_num.neg = st[STAGES].neg;

endmodule

FILE: hw/rtl/b2d_emit.sv
module b2d_emit import b2d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  b2d_num_t   in_num,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] character,
  output logic       last
);

  logic                busy;
  logic                sign;
  logic [IDX_BITS-1:0] idx;
  logic [IDX_BITS-1:0] hi;
  logic [BCD_BITS-1:0] bcd;
  logic [3:0]          digit;

  // top non-zero digit
  always_comb begin
    hi = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (in_num.bcd[4*i +: 4] != 4'd0) begin
        hi = IDX_BITS'(i);
      end
    end
  end

  assign last      = ~sign & (idx == '0);
  assign out_valid = busy;
  assign in_ready  = ~busy | (out_ready & last);
  assign digit     = bcd[4*idx +: 4];
  assign character = sign ? CHAR_MINUS : (CHAR_ZERO + 8'(digit));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sign <= 1'b0;
      idx  <= '0;
    end else if (in_ready) begin
      busy <= in_valid;
      sign <= in_num.neg;
      idx  <= hi;
    end else if (out_ready) begin
      if (sign) begin
        sign <= 1'b0;
      end else begin
        idx <= idx - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      bcd <= in_num.bcd;
    end
  end

endmodule

FILE: hw/rtl/binary_to_decimal_ascii.sv
// channel  dir  payload                        word accepted
// num      in   value[31:0], mode              num.valid & num.ready
// text     out  character[7:0], last           text.valid & text.ready
//
// a number runs through a nine-stage pipeline (magnitude, then eight
// double-dabble stages of four shift steps each) ahead of the text stage; the
// text stage sends one character per cycle while text is not stalled, and a
// number gives 1 to 11 characters, which sets the sustained rate
// reset clears the valid bits of every stage; a stall on text holds every full
// stage in place while empty stages still fill, nothing is dropped or sent twice
module binary_to_decimal_ascii import b2d_pkg::*; (
  input logic     clk,
  input logic     rst,
  b2d_in_if.sink  num,
  b2d_out_if.source text
);

  logic     num_valid;
  logic     num_ready;
  b2d_num_t num_word;

  b2d_dabble u_dabble (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (num.valid),
    .in_ready  (num.ready),
    .value     (num.value),
    .mode      (num.mode),
    .out_valid (num_valid),
    .out_ready (num_ready),
    .out_num   (num_word)
  );

  b2d_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (num_valid),
    .in_ready  (num_ready),
    .in_num    (num_word),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .character (text.character),
    .last      (text.last)
  );

endmodule

FILE: hw/rtl/b2d_check.sv
module b2d_check (
  input logic       clk,
  input logic       rst,
  input logic       text_valid,
  input logic       text_ready,
  input logic [7:0] character,
  input logic       last
);

  localparam logic [7:0] MINUS = 8'h2d;
  localparam logic [7:0] ZERO  = 8'h30;
  localparam logic [7:0] NINE  = 8'h39;

  a_reset_idle: assert property (@(posedge clk) rst |=> !text_valid)
    else $error("text valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_ready |=> text_valid && $stable(character) && $stable(last))
    else $error("stalled word changed");

  a_charset: assert property (@(posedge clk) disable iff (rst)
    text_valid |-> character == MINUS || (character >= ZERO && character <= NINE))
    else $error("bad character");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    text_valid && character == MINUS |-> !last)
    else $error("minus sign closes a number");

  a_minus_then_digit: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_ready && character == MINUS
      |=> text_valid && character != ZERO && character != MINUS)
    else $error("minus sign not followed by a leading digit");

endmodule

bind binary_to_decimal_ascii b2d_check u_check (
  .clk        (clk),
  .rst        (rst),
  .text_valid (text.valid),
  .text_ready (text.ready),
  .character  (text.character),
  .last       (text.last)
);

FILE: sim/b2d_tb_pkg.sv
`timescale 1ns / 1ps
package b2d_tb_pkg;

  typedef enum logic {
    MODE_SIGNED   = 1'b0,
    MODE_UNSIGNED = 1'b1
  } num_mode_e;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

endpackage

FILE: sim/b2d_text_checker.sv
`timescale 1ns / 1ps
module b2d_text_checker import b2d_pkg::*, b2d_tb_pkg::*; (
  input  logic clk,
  input  logic rst,
  b2d_in_if    num,
  b2d_out_if   text,
  output int   fail_count,
  output int   pending
);

  text_char_t expected_text[$];
  text_char_t want;
  int         mismatches = 0;

  // decimal text of one number, most significant character first
  function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] value,
                                             input logic mode);
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] magnitude;
    logic [WORD_BITS-1:0] remainder;
    logic [7:0]           digits[$];
    logic                 negative;
    word      = value[WORD_BITS-1:0];
    negative  = (mode == MODE_SIGNED) && word[WORD_BITS-1];
    magnitude = negative ? ~word + 1'b1 : word;
    do begin
      remainder = magnitude % 10;
      digits.push_front(CHAR_ZERO + remainder[7:0]);
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (negative) begin
      expected_text.push_back('{character: CHAR_MINUS, last: 1'b0});
    end
    foreach (digits[i]) begin
      expected_text.push_back('{character: digits[i], last: (i == digits.size() - 1)});
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (num.valid && num.ready) begin
        queue_decimal_text(num.value, num.mode);
      end
      if (text.valid && text.ready) begin
        if (expected_text.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected word char %h last %b, nothing pending",
                     $realtime, text.character, text.last);
          end
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          if (text.character !== want.character || text.last !== want.last) begin
            if (mismatches < 10) begin
              $display("%0t: text mismatch: expected char %h last %b, got char %h last %b",
                       $realtime, want.character, want.last, text.character, text.last);
            end
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_text.size();
  end

endmodule

FILE: sim/tb_binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
module tb_binary_to_decimal_ascii;
  import b2d_pkg::*;
  import b2d_tb_pkg::*;

  localparam int IDLE_LIMIT     = 2000;
  localparam int RANDOM_NUMBERS = 350;
  localparam int SETTLE_CYCLES  = 24;

  logic        clk = 1'b0;
  logic        rst;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  logic [15:0] stall_pattern = '1;
  int          pattern_age = 0;

  b2d_in_if  num_ch ();
  b2d_out_if text_ch ();

  binary_to_decimal_ascii dut (
    .clk (clk),
    .rst (rst),
    .num (num_ch),
    .text(text_ch)
  );

  b2d_text_checker text_check (
    .clk       (clk),
    .rst       (rst),
    .num       (num_ch),
    .text      (text_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  // receiver stalls follow a rotating pattern, reloaded now and then
  always @(posedge clk) begin
    text_ch.ready <= stall_pattern[0];
    if (pattern_age == 0) begin
      pattern_age <= $urandom_range(32, 256);
      case ($urandom_range(0, 3))
        0: stall_pattern <= '1;
        1: stall_pattern <= 16'($urandom_range(0, 65535) & $urandom_range(0, 65535) | 16'h0001);
        default: stall_pattern <= 16'($urandom_range(0, 65535) | 16'h0001);
      endcase
    end else begin
      pattern_age   <= pattern_age - 1;
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  always @(posedge clk) begin
    if (rst || (num_ch.valid && num_ch.ready) || (text_ch.valid && text_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_number(input logic [VALUE_BITS-1:0] value, input num_mode_e mode);
    num_ch.valid <= 1'b1;
    num_ch.value <= value;
    num_ch.mode  <= mode;
    do @(posedge clk); while (!(num_ch.valid && num_ch.ready));
  endtask

  task automatic drain_text();
    num_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [VALUE_BITS-1:0] value;
    num_mode_e             mode;
    int                    burst_left;
    int                    gap;
    longint unsigned       lo;
    longint unsigned       hi;

    rst           = 1'b1;
    num_ch.valid  = 1'b0;
    num_ch.value  = '0;
    num_ch.mode   = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_number(32'd0, MODE_SIGNED);
    send_number(32'd0, MODE_UNSIGNED);
    send_number(32'd1, MODE_SIGNED);
    send_number(32'd9, MODE_UNSIGNED);
    send_number(32'd10, MODE_SIGNED);
    send_number(32'd99, MODE_SIGNED);
    send_number(32'd100, MODE_UNSIGNED);
    send_number(32'h7fff_ffff, MODE_SIGNED);
    send_number(32'h8000_0000, MODE_SIGNED);
    send_number(32'h8000_0000, MODE_UNSIGNED);
    send_number(32'h8000_0001, MODE_SIGNED);
    send_number(32'hffff_ffff, MODE_SIGNED);
    send_number(32'hffff_ffff, MODE_UNSIGNED);
    send_number(32'hffff_fff6, MODE_SIGNED);
    send_number(32'd999_999_999, MODE_SIGNED);
    send_number(32'd1_000_000_000, MODE_UNSIGNED);
    send_number(32'd4_000_000_000, MODE_SIGNED);
    send_number(32'd4_000_000_000, MODE_UNSIGNED);
    send_number(32'h5555_5555, MODE_SIGNED);
    send_number(32'haaaa_aaaa, MODE_SIGNED);
    send_number(32'haaaa_aaaa, MODE_UNSIGNED);
    drain_text();

    burst_left = 0;
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      if (burst_left == 0) begin
        case ($urandom_range(0, 7))
          0, 1: gap = 0;
          2, 3, 4, 5: gap = $urandom_range(1, 3);
          6: gap = $urandom_range(4, 12);
          default: gap = $urandom_range(13, 30);
        endcase
        if (gap != 0) begin
          num_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 16);
      end
      case ($urandom_range(0, 5))
        0: value = $urandom;
        1: value = $urandom_range(0, 20);
        2: value = -$urandom_range(1, 20);
        3: begin
          // uniform digit count, then a value with that many digits
          lo = 1;
          repeat ($urandom_range(0, 9)) lo = lo * 10;
          hi = lo * 10 - 1;
          if (hi > 64'hffff_ffff) begin
            hi = 64'hffff_ffff;
          end
          value = VALUE_BITS'(lo + longint'($urandom) % (hi - lo + 1));
        end
        4: begin
          lo = 1;
          repeat ($urandom_range(0, 9)) lo = lo * 10;
          value = VALUE_BITS'(lo + $urandom_range(0, 2) - 1);
        end
        default: value = 32'h7fff_fffd + $urandom_range(0, 5);
      endcase
      mode = num_mode_e'($urandom_range(0, 1));
      send_number(value, mode);
      burst_left--;
      if (i == RANDOM_NUMBERS / 2) begin
        drain_text();
      end
    end

    drain_text();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
